### rtl/positional_array_list_macros.svh
// assertion macros shared by the list modules
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

`ifndef NO_ASSERTIONS

// implication checked on every rising edge outside reset
`define PAL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("positional_array_list: check failed");

// condition that must never be seen outside reset
`define PAL_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("positional_array_list: forbidden condition seen");

`else

`define PAL_ASSERT(lbl, clk, rst_n, prop)
`define PAL_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

  // operation codes
  localparam logic [2:0] MODE_APPEND_END   = 3'd0;
  localparam logic [2:0] MODE_APPEND_FRONT = 3'd1;
  localparam logic [2:0] MODE_INSERT_AT    = 3'd2;
  localparam logic [2:0] MODE_DELETE_END   = 3'd3;
  localparam logic [2:0] MODE_DELETE_FRONT = 3'd4;
  localparam logic [2:0] MODE_DELETE_AT    = 3'd5;
  localparam logic [2:0] MODE_READ_AT      = 3'd6;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  // input transaction
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [4:0]         position;
  } in_item_t;

  // result transaction
  typedef struct packed {
    status_t            status;
    logic [5:0]         count;
    logic signed [31:0] read_value;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } pal_cmd_t;

endpackage

### rtl/positional_array_list.sv
// positional_array_list: ordered packed list of up to CAPACITY signed words
// input channel in_valid / in_ready / in_data carries one operation per
// transaction: append end or front, insert, delete end, front or at a
// position, or read at a position; every transaction gives one result
// result channel out_valid / out_ready / out_data reports status, the
// entry count after the operation and the read word (zero unless a read)
// an accepted operation is latched in the idle state and executed in the
// execute state once the result register is free, shifting the cell row
// and registering the result; no new transaction is taken before that
// a failed operation reports full, empty or range and changes nothing
// a stalled receiver holds the result; one more transaction is accepted
// and waits in the datapath until the result register drains
// reset clears the fill count and the control state; cell contents are
// left as they are and only entries below the count are ever read
`timescale 1ns / 1ps

module positional_array_list #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pal_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pal_pkg::out_item_t out_data
);
  import pal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  pal_cmd_t cmd;

  // sequencing
  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // cell row, checks and result register
  pal_datapath #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_data),
    .out_item (out_data)
  );

endmodule

### rtl/pal_ctrl.sv
`timescale 1ns / 1ps

`include "positional_array_list_macros.svh"

module pal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pal_pkg::pal_cmd_t cmd
);
  import pal_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && (state_r == S_IDLE);
  assign cmd.execute = (state_r == S_EXEC) && slot_free;
  assign out_valid   = out_valid_r;

  // next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an executed operation always presents a result next cycle
  `PAL_ASSERT(a_exec_gives_result, clk, rst_n, cmd.execute |=> out_valid)
  // a captured transaction moves to the execute state next
  `PAL_ASSERT(a_capture_to_exec, clk, rst_n, cmd.capture |=> (state_r == S_EXEC))
  // a stalled receiver holds the pending operation
  `PAL_ASSERT(a_stall_holds, clk, rst_n,
              (state_r == S_EXEC && out_valid_r && !out_ready) |=> (state_r == S_EXEC))

endmodule

### rtl/pal_datapath.sv
`timescale 1ns / 1ps

`include "positional_array_list_macros.svh"

module pal_datapath #(
  parameter int CAPACITY = 32,
  parameter int CW       = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pal_pkg::pal_cmd_t  cmd,
  input  pal_pkg::in_item_t  in_item,
  output pal_pkg::out_item_t out_item
);
  import pal_pkg::*;

  localparam int PW    = (CW > 5) ? CW : 5;
  localparam int NREAD = (CAPACITY < 32) ? CAPACITY : 32;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  in_item_t           op_r;
  logic signed [31:0] cell_r   [CAPACITY];
  logic signed [31:0] cell_nxt [CAPACITY];
  logic [CW-1:0]      count_r, count_nxt;
  out_item_t          out_r;

  logic               do_ins, do_del;
  logic [PW-1:0]      at_w;
  logic [CW-1:0]      at;
  logic [PW-1:0]      pos_ext, cnt_ext;
  status_t            status;
  logic signed [31:0] rd_cell, rd_value;

  assign pos_ext = PW'(op_r.position);
  assign cnt_ext = PW'(count_r);
  assign at      = at_w[CW-1:0];

  // read mux over the addressable cells
  always_comb begin
    rd_cell = '0;
    for (int i = 0; i < NREAD; i++) begin
      if (op_r.position == 5'(i)) begin
        rd_cell = cell_r[i];
      end
    end
  end

  // operation decode, checks and target index
  always_comb begin
    do_ins   = 1'b0;
    do_del   = 1'b0;
    at_w     = '0;
    status   = STATUS_OK;
    rd_value = '0;
    count_nxt = count_r;
    case (op_r.mode) inside
      MODE_APPEND_END, MODE_APPEND_FRONT, MODE_INSERT_AT: begin
        if (op_r.mode == MODE_APPEND_END) begin
          at_w = cnt_ext;
        end else if (op_r.mode == MODE_INSERT_AT) begin
          at_w = pos_ext;
        end
        if (count_r == CAP_C) begin
          status = STATUS_FULL;
        end else if (at_w > cnt_ext) begin
          status = STATUS_RANGE;
        end else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_DELETE_END, MODE_DELETE_FRONT, MODE_DELETE_AT: begin
        if (op_r.mode == MODE_DELETE_END) begin
          at_w = cnt_ext - 1'b1;
        end else if (op_r.mode == MODE_DELETE_AT) begin
          at_w = pos_ext;
        end
        if (count_r == '0) begin
          status = STATUS_EMPTY;
        end else if (at_w >= cnt_ext) begin
          status = STATUS_RANGE;
        end else begin
          do_del    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      MODE_READ_AT: begin
        if (count_r == '0) begin
          status = STATUS_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = STATUS_RANGE;
        end else begin
          rd_value = rd_cell;
        end
      end
      default: begin
      end
    endcase
  end

  // each cell shifts up, shifts down, loads or holds
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(g);
    always_comb begin
      cell_nxt[g] = cell_r[g];
      if (do_ins && IDX == at) begin
        cell_nxt[g] = op_r.value;
      end
      if (g > 0) begin
        if (do_ins && IDX > at) begin
          cell_nxt[g] = cell_r[(g > 0) ? g - 1 : 0];
        end
      end
      if (g < CAPACITY - 1) begin
        if (do_del && IDX >= at) begin
          cell_nxt[g] = cell_r[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  // operation latch, cell row and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_item;
    end
    if (cmd.execute) begin
      cell_r           <= cell_nxt;
      out_r.status     <= status;
      out_r.count      <= 6'(count_nxt);
      out_r.read_value <= rd_value;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  assign out_item = out_r;

  // fill count stays within capacity
  `PAL_NEVER(a_count_bound, clk, rst_n, count_r > CAP_C)
  // the list changes only on an executed operation
  `PAL_ASSERT(a_count_stable, clk, rst_n, !cmd.execute |=> $stable(count_r))
  // a full report leaves the list full
  `PAL_ASSERT(a_full_holds, clk, rst_n,
              (cmd.execute && status == STATUS_FULL) |=> (count_r == CAP_C))

endmodule
